[hdl/dim_pkg.sv]
// ----------------------------------------------------------------------------
// dim_pkg: shared types and constants for the digital input filter mapper
// Channel count, field widths, polarity and register codes, lane structs and
// helpers that turn a function number into a command-word bit.
// ----------------------------------------------------------------------------
package dim_pkg;

    localparam int CHANNELS   = 8;
    localparam int FUNC_W     = 6;
    localparam int FUNCS      = 32;
    localparam int POL_W      = 3;
    localparam int CNT_W      = 16;
    localparam int PIN_W      = CHANNELS;
    localparam int FUNC_MAP_W = CHANNELS * FUNC_W;
    localparam int POL_MAP_W  = CHANNELS * POL_W;
    localparam int FILT_HALF  = (CHANNELS / 2) * CNT_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Polarity codes; codes above POL_EDGE mean nothing and hold the bit
    typedef enum logic [POL_W-1:0] {
        POL_LOW  = 3'd0,
        POL_HIGH = 3'd1,
        POL_RISE = 3'd2,
        POL_FALL = 3'd3,
        POL_EDGE = 3'd4
    } polarity_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FUNCTION_MAP = 3'd0,
        REG_POLARITY_MAP = 3'd1,
        REG_FILTER_LOW   = 3'd2,
        REG_FILTER_HIGH  = 3'd3,
        REG_PASSIVE      = 3'd4
    } reg_index_t;

    // Per-lane control from the claim resolver
    typedef struct packed {
        logic touched;        // channel reached this tick
        logic conflict_here;  // channel is the first duplicate claim
    } lane_ctl_t;

    // Per-lane effect on the command word: clear first, then set
    typedef struct packed {
        logic [FUNCS-1:0] clr_bits;
        logic [FUNCS-1:0] set_bits;
    } lane_cmd_t;

    typedef struct packed {
        logic [FUNCS-1:0]    control_word;
        logic [CHANNELS-1:0] logic_levels;
        logic [CHANNELS-1:0] filtered_levels;
        logic                conflict;
    } result_t;

    // Function number names a real command bit
    function automatic logic func_valid(input logic [FUNC_W-1:0] f);
        return (f != '0) && (f <= FUNC_W'(FUNCS));
    endfunction

    // Function drives its bit (valid and not the passive one)
    function automatic logic func_drives(input logic [FUNC_W-1:0] f,
                                         input logic [FUNC_W-1:0] passive);
        return func_valid(f) && (f != passive);
    endfunction

    // One-hot command bit of a function, zero for an invalid number
    function automatic logic [FUNCS-1:0] func_bit(input logic [FUNC_W-1:0] f);
        logic [FUNCS-1:0] b;
        b = '0;
        if (func_valid(f))
        begin
            b = FUNCS'(1) << (f - FUNC_W'(1));
        end
        return b;
    endfunction

endpackage

[hdl/dim_if.sv]
// ----------------------------------------------------------------------------
// dim_if: channel interfaces of the digital input filter mapper
// Pin sample channel, result channel and configuration write channel, each
// with valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface dim_pin_if;
    logic                        valid;
    logic                        ready;
    logic [dim_pkg::PIN_W-1:0]   pin_levels;

    modport source (output valid, output pin_levels, input ready);
    modport sink   (input valid, input pin_levels, output ready);
endinterface

interface dim_result_if;
    logic                          valid;
    logic                          ready;
    logic [dim_pkg::FUNCS-1:0]     control_word;
    logic [dim_pkg::CHANNELS-1:0]  logic_levels;
    logic [dim_pkg::CHANNELS-1:0]  filtered_levels;
    logic                          conflict;

    modport source (output valid, output control_word, output logic_levels,
                    output filtered_levels, output conflict, input ready);
    modport sink   (input valid, input control_word, input logic_levels,
                    input filtered_levels, input conflict, output ready);
endinterface

interface dim_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [dim_pkg::CFG_IDX_W-1:0]   index;
    logic [dim_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/dim_claim.sv]
// ----------------------------------------------------------------------------
// dim_claim: function claim resolver
// Compares the function numbers of all channels pairwise, finds the first
// channel that claims a function already taken, and tells each lane whether
// it is reached this tick and whether it is the conflicting one.
// ----------------------------------------------------------------------------
module dim_claim (
    input  logic [dim_pkg::FUNC_W-1:0] func_sel [dim_pkg::CHANNELS],
    output dim_pkg::lane_ctl_t         ctl      [dim_pkg::CHANNELS],
    output logic                       conflict
);

    logic [dim_pkg::CHANNELS-1:0] dup;

    // Flag every valid claim that repeats a lower channel's claim
    always_comb
    begin
        for (int c = 0; c < dim_pkg::CHANNELS; c++)
        begin
            dup[c] = 1'b0;
            for (int j = 0; j < c; j++)
            begin
                if (dim_pkg::func_valid(func_sel[c]) && (func_sel[j] == func_sel[c]))
                begin
                    dup[c] = 1'b1;
                end
            end
        end
    end

    // Reach channels up to and including the first duplicate
    always_comb
    begin
        logic seen;
        seen = 1'b0;
        for (int c = 0; c < dim_pkg::CHANNELS; c++)
        begin
            ctl[c].touched       = !seen;
            ctl[c].conflict_here = dup[c] && !seen;
            seen                 = seen || dup[c];
        end
    end

    assign conflict = |dup;

endmodule

[hdl/dim_lane.sv]
// ----------------------------------------------------------------------------
// dim_lane: one input channel
// Holds the channel's debounce counter, raw and filtered level, logic level
// and active function; computes its next state and its effect on the
// command word for the sample being transferred.
// ----------------------------------------------------------------------------
module dim_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          pin,
    input  logic [dim_pkg::FUNC_W-1:0]    func,
    input  logic [dim_pkg::POL_W-1:0]     polarity,
    input  logic [dim_pkg::CNT_W-1:0]     filter_time,
    input  logic [dim_pkg::FUNC_W-1:0]    passive,
    input  dim_pkg::lane_ctl_t            ctl,
    output logic                          filtered_level,
    output logic                          logic_level,
    output dim_pkg::lane_cmd_t            cmd
);

    logic [dim_pkg::FUNC_W-1:0] active_reg, active_next;
    logic [dim_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                       raw_reg, raw_next;
    logic                       filt_reg, filt_next;
    logic                       logic_reg, logic_next;

    logic                       changed;
    logic                       process;
    logic [dim_pkg::CNT_W-1:0]  count_inc;
    logic                       qualify;
    logic [dim_pkg::FUNCS-1:0]  own_bit;
    logic                       drive;

    // Function change and whether the channel is filtered this tick
    assign changed = ctl.touched && (active_reg != func);
    assign process = ctl.touched && !ctl.conflict_here && dim_pkg::func_valid(func);
    assign own_bit = dim_pkg::func_bit(func);
    assign drive   = dim_pkg::func_drives(func, passive);

    // Restart on a raw change, then count and compare against the filter time
    assign count_inc = ((raw_reg != pin) ? '0 : count_reg) + dim_pkg::CNT_W'(1);
    assign qualify   = count_inc > filter_time;

    // Next state of the channel
    always_comb
    begin
        active_next = changed ? func : active_reg;
        raw_next    = raw_reg;
        count_next  = count_reg;
        filt_next   = filt_reg;
        logic_next  = logic_reg;
        if (process)
        begin
            raw_next   = pin;
            count_next = qualify ? '0 : count_inc;
            filt_next  = qualify ? pin : filt_reg;
            case (dim_pkg::polarity_t'(polarity))
                dim_pkg::POL_LOW:  logic_next = filt_next;
                dim_pkg::POL_HIGH: logic_next = !filt_next;
                default:           logic_next = logic_reg;
            endcase
        end
    end

    // Command word effect: drop the old function's bit, then drive the new one
    always_comb
    begin
        cmd.clr_bits = '0;
        cmd.set_bits = '0;
        if (changed && dim_pkg::func_drives(active_reg, passive))
        begin
            cmd.clr_bits = dim_pkg::func_bit(active_reg);
        end
        if (drive && ctl.conflict_here)
        begin
            cmd.clr_bits = cmd.clr_bits | own_bit;
        end
        else if (drive && process)
        begin
            if (logic_next)
            begin
                cmd.set_bits = own_bit;
            end
            else
            begin
                cmd.clr_bits = cmd.clr_bits | own_bit;
            end
        end
    end

    // Hold channel state between transfers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            count_reg  <= '0;
            raw_reg    <= 1'b0;
            filt_reg   <= 1'b0;
            logic_reg  <= 1'b0;
        end
        else if (advance)
        begin
            active_reg <= active_next;
            count_reg  <= count_next;
            raw_reg    <= raw_next;
            filt_reg   <= filt_next;
            logic_reg  <= logic_next;
        end
    end

    assign filtered_level = filt_next;
    assign logic_level    = logic_next;

endmodule

[hdl/dim_merge.sv]
// ----------------------------------------------------------------------------
// dim_merge: command word merge
// Applies the lanes' clear and set masks to the command word in channel
// order, so a later channel's change overrides an earlier one's.
// ----------------------------------------------------------------------------
module dim_merge (
    input  logic [dim_pkg::FUNCS-1:0] base_word,
    input  dim_pkg::lane_cmd_t        cmd [dim_pkg::CHANNELS],
    output logic [dim_pkg::FUNCS-1:0] merged_word
);

    // Fold lane effects in index order
    always_comb
    begin
        logic [dim_pkg::FUNCS-1:0] w;
        w = base_word;
        for (int c = 0; c < dim_pkg::CHANNELS; c++)
        begin
            w = (w & ~cmd[c].clr_bits) | cmd[c].set_bits;
        end
        merged_word = w;
    end

endmodule

[hdl/digital_input_filter_mapper.sv]
// ----------------------------------------------------------------------------
// digital_input_filter_mapper: debounced digital inputs mapped to functions
// Throughput: one sample per cycle while the skid stage is empty; all channel
// lanes update in the transfer cycle and the command word is merged across
// lanes in that same cycle.
// A two-entry output buffer keeps input transfers going while a result waits.
// Reset clears all channel state, the command word and the configuration.
// ----------------------------------------------------------------------------
module digital_input_filter_mapper (
    input  logic          clk,
    input  logic          rst_n,
    dim_pin_if.sink       pins,
    dim_result_if.source  results,
    dim_cfg_if.sink       cfg
);

    logic [dim_pkg::FUNC_MAP_W-1:0] function_map_reg;
    logic [dim_pkg::POL_MAP_W-1:0]  polarity_map_reg;
    logic [dim_pkg::FILT_HALF-1:0]  filter_low_reg;
    logic [dim_pkg::FILT_HALF-1:0]  filter_high_reg;
    logic [dim_pkg::FUNC_W-1:0]     passive_reg;

    logic [dim_pkg::FUNCS-1:0]      command_reg, command_next;

    dim_pkg::result_t               out_data_reg, skid_data_reg;
    logic                           out_valid_reg, skid_valid_reg;

    logic                           accept;
    logic                           pop;
    dim_pkg::result_t               result;

    logic [2*dim_pkg::FILT_HALF-1:0] filter_all;
    logic [dim_pkg::FUNC_W-1:0]      func_sel  [dim_pkg::CHANNELS];
    dim_pkg::lane_ctl_t              ctl       [dim_pkg::CHANNELS];
    dim_pkg::lane_cmd_t              cmd       [dim_pkg::CHANNELS];
    logic [dim_pkg::CHANNELS-1:0]    filt_next;
    logic [dim_pkg::CHANNELS-1:0]    logic_next;
    logic [dim_pkg::CHANNELS-1:0]    conflict_here_vec;
    logic                            conflict;

    assign accept = pins.valid && pins.ready;
    assign pop    = out_valid_reg && results.ready;

    // Configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            function_map_reg <= '0;
            polarity_map_reg <= '0;
            filter_low_reg   <= '0;
            filter_high_reg  <= '0;
            passive_reg      <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                dim_pkg::REG_FUNCTION_MAP:
                    function_map_reg <= cfg.data[dim_pkg::FUNC_MAP_W-1:0];
                dim_pkg::REG_POLARITY_MAP:
                    polarity_map_reg <= cfg.data[dim_pkg::POL_MAP_W-1:0];
                dim_pkg::REG_FILTER_LOW:
                    filter_low_reg   <= cfg.data[dim_pkg::FILT_HALF-1:0];
                dim_pkg::REG_FILTER_HIGH:
                    filter_high_reg  <= cfg.data[dim_pkg::FILT_HALF-1:0];
                dim_pkg::REG_PASSIVE:
                    passive_reg      <= cfg.data[dim_pkg::FUNC_W-1:0];
                default:
                    ;
            endcase
        end
    end

    assign filter_all = {filter_high_reg, filter_low_reg};

    // Resolve claims across channels
    dim_claim u_claim (
        .func_sel (func_sel),
        .ctl      (ctl),
        .conflict (conflict)
    );

    // Channel lanes
    for (genvar c = 0; c < dim_pkg::CHANNELS; c++)
    begin : g_lane
        assign func_sel[c]          = function_map_reg[c*dim_pkg::FUNC_W +: dim_pkg::FUNC_W];
        assign conflict_here_vec[c] = ctl[c].conflict_here;

        dim_lane u_lane (
            .clk            (clk),
            .rst_n          (rst_n),
            .advance        (accept),
            .pin            (pins.pin_levels[c]),
            .func           (func_sel[c]),
            .polarity       (polarity_map_reg[c*dim_pkg::POL_W +: dim_pkg::POL_W]),
            .filter_time    (filter_all[c*dim_pkg::CNT_W +: dim_pkg::CNT_W]),
            .passive        (passive_reg),
            .ctl            (ctl[c]),
            .filtered_level (filt_next[c]),
            .logic_level    (logic_next[c]),
            .cmd            (cmd[c])
        );
    end

    // Merge lane effects into the command word
    dim_merge u_merge (
        .base_word   (command_reg),
        .cmd         (cmd),
        .merged_word (command_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_reg <= '0;
        end
        else if (accept)
        begin
            command_reg <= command_next;
        end
    end

    // Assemble the result of this transfer
    always_comb
    begin
        result.control_word    = command_next;
        result.logic_levels    = logic_next;
        result.filtered_levels = filt_next;
        result.conflict        = conflict;
    end

    // Two-entry output buffer: output stage plus skid stage
    assign pins.ready = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= accept;
            end
            else
            begin
                out_valid_reg  <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
                if (accept)
                begin
                    skid_data_reg <= result;
                end
            end
            else if (accept)
            begin
                out_data_reg <= result;
            end
        end
        else if (accept)
        begin
            skid_data_reg <= result;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.control_word    = out_data_reg.control_word;
    assign results.logic_levels    = out_data_reg.logic_levels;
    assign results.filtered_levels = out_data_reg.filtered_levels;
    assign results.conflict        = out_data_reg.conflict;

    // A waiting skid entry always sits behind a valid output entry
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output entry");

    // After every transfer the output stage holds a valid entry
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("transfer produced no result");

    // At most one lane is the first duplicate claim
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(conflict_here_vec))
        else $error("more than one conflicting lane");

    // The conflict flag is raised only when exactly one lane conflicts
    assert property (@(posedge clk) disable iff (!rst_n)
        conflict |-> $onehot(conflict_here_vec))
        else $error("conflict flag without a conflicting lane");

endmodule

[sim/dim_tick_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dim_tick_checker: scoreboard for the digital input filter mapper
// Watches the pin, result and configuration channels. Keeps its own copy of
// the registers and the channel state, computes the result of every pin
// sample transfer and compares each result transfer against the oldest one.
// ----------------------------------------------------------------------------
module dim_tick_checker (
    input  logic   clk,
    input  logic   rst_n,
    dim_pin_if     pin_mon,
    dim_result_if  res_mon,
    dim_cfg_if     cfg_mon,
    output int     errors,
    output int     outstanding,
    output int     compared,
    output int     conflicts
);
    import dim_pkg::*;

    // Shadow registers
    logic [FUNC_MAP_W-1:0] fn_map;
    logic [POL_MAP_W-1:0]  pol_map;
    logic [FILT_HALF-1:0]  filt_lo;
    logic [FILT_HALF-1:0]  filt_hi;
    logic [FUNC_W-1:0]     passive_fn;

    // Shadow channel state
    logic [FUNC_W-1:0]     active_fn [CHANNELS];
    logic [CNT_W-1:0]      hold_count [CHANNELS];
    logic [CHANNELS-1:0]   raw_level;
    logic [CHANNELS-1:0]   debounced;
    logic [CHANNELS-1:0]   logic_lvl;
    logic [FUNCS-1:0]      cmd_word;

    // Results computed but not yet seen on the result channel
    result_t tick_results [$];

    // True when a function number owns a command bit
    function automatic logic owns_bit(input logic [FUNC_W-1:0] f);
        return (f != '0) && (f <= FUNCS) && (f != passive_fn);
    endfunction

    task automatic drive_cmd(input logic [FUNC_W-1:0] f, input logic on);
        if (owns_bit(f))
        begin
            cmd_word[f - 1] = on;
        end
    endtask

    // Advance every channel by one pin sample and build the result
    task automatic filter_and_map(input logic [PIN_W-1:0] pins, output result_t r);
        logic [FUNCS-1:0]  claimed;
        logic              clash;
        logic [FUNC_W-1:0] f;
        logic [CNT_W-1:0]  limit;
        int                c;
        claimed = '0;
        clash   = 1'b0;
        for (c = 0; c < CHANNELS && !clash; c++)
        begin
            f = fn_map[c*FUNC_W +: FUNC_W];
            // Function change: drop the old bit first
            if (active_fn[c] != f)
            begin
                drive_cmd(active_fn[c], 1'b0);
                active_fn[c] = f;
            end
            if (f != '0 && f <= FUNCS)
            begin
                if (claimed[f - 1])
                begin
                    // Second claim: clear the bit and skip the rest
                    drive_cmd(f, 1'b0);
                    clash = 1'b1;
                end
                else
                begin
                    claimed[f - 1] = 1'b1;
                    // Restart the debounce count on a raw change
                    if (raw_level[c] != pins[c])
                    begin
                        raw_level[c]  = pins[c];
                        hold_count[c] = '0;
                    end
                    hold_count[c] = hold_count[c] + 1'b1;
                    limit = (c < CHANNELS / 2) ? filt_lo[c*CNT_W +: CNT_W]
                                               : filt_hi[(c - CHANNELS / 2)*CNT_W +: CNT_W];
                    if (hold_count[c] > limit)
                    begin
                        debounced[c]  = pins[c];
                        hold_count[c] = '0;
                    end
                    // Level polarities follow the pin, edge modes hold
                    case (polarity_t'(pol_map[c*POL_W +: POL_W]))
                        POL_LOW:  logic_lvl[c] = debounced[c];
                        POL_HIGH: logic_lvl[c] = ~debounced[c];
                        default:  ;
                    endcase
                    drive_cmd(f, logic_lvl[c]);
                end
            end
        end
        r.control_word    = cmd_word;
        r.logic_levels    = logic_lvl;
        r.filtered_levels = debounced;
        r.conflict        = clash;
    endtask

    task automatic compare_field(input string field, input logic [FUNCS-1:0] want,
                                 input logic [FUNCS-1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
        end
    endtask

    // Track configuration writes, sample transfers and result transfers
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        result_t got;
        int      c;
        if (!rst_n)
        begin
            fn_map     = '0;
            pol_map    = '0;
            filt_lo    = '0;
            filt_hi    = '0;
            passive_fn = '0;
            for (c = 0; c < CHANNELS; c++)
            begin
                active_fn[c]  = '0;
                hold_count[c] = '0;
            end
            raw_level   = '0;
            debounced   = '0;
            logic_lvl   = '0;
            cmd_word    = '0;
            tick_results.delete();
            errors      = 0;
            outstanding = 0;
            compared    = 0;
            conflicts   = 0;
        end
        else
        begin
            // Register write transfer
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                case (reg_index_t'(cfg_mon.index))
                    REG_FUNCTION_MAP: fn_map     = cfg_mon.data[FUNC_MAP_W-1:0];
                    REG_POLARITY_MAP: pol_map    = cfg_mon.data[POL_MAP_W-1:0];
                    REG_FILTER_LOW:   filt_lo    = cfg_mon.data[FILT_HALF-1:0];
                    REG_FILTER_HIGH:  filt_hi    = cfg_mon.data[FILT_HALF-1:0];
                    REG_PASSIVE:      passive_fn = cfg_mon.data[FUNC_W-1:0];
                    default:          ;
                endcase
            end
            // Result transfer: compare against the oldest expectation
            if (res_mon.valid && res_mon.ready)
            begin
                got.control_word    = res_mon.control_word;
                got.logic_levels    = res_mon.logic_levels;
                got.filtered_levels = res_mon.filtered_levels;
                got.conflict        = res_mon.conflict;
                if (tick_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result expected none, got %h", $time, got);
                end
                else
                begin
                    want = tick_results.pop_front();
                    compared++;
                    if (want.conflict)
                    begin
                        conflicts++;
                    end
                    compare_field("control_word", want.control_word, got.control_word);
                    compare_field("logic_levels", FUNCS'(want.logic_levels),
                                  FUNCS'(got.logic_levels));
                    compare_field("filtered_levels", FUNCS'(want.filtered_levels),
                                  FUNCS'(got.filtered_levels));
                    compare_field("conflict", FUNCS'(want.conflict), FUNCS'(got.conflict));
                end
            end
            // Pin sample transfer
            if (pin_mon.valid && pin_mon.ready)
            begin
                filter_and_map(pin_mon.pin_levels, want);
                tick_results.push_back(want);
            end
            outstanding = tick_results.size();
        end
    end

endmodule

[sim/digital_input_filter_mapper_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// digital_input_filter_mapper_test: stimulus and verdict for the filter mapper
// Runs a directed pass over polarities, filter extremes, function changes,
// passive functions and duplicate claims, then random phases of pin activity
// under fresh register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module digital_input_filter_mapper_test;
    import dim_pkg::*;

    localparam int PHASES       = 14;
    localparam int PHASE_ITEMS  = 125;
    localparam int IDLE_PCT     = 20;
    localparam int DRAIN_CYCLES = 4;
    localparam int STALL_LIMIT  = 4000;

    // Index with no register behind it, and polarity codes with no meaning
    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 3'd7;
    localparam logic [POL_W-1:0]     POL_RSVD_5 = 3'd5;
    localparam logic [POL_W-1:0]     POL_RSVD_7 = 3'd7;

    logic clk;
    logic rst_n;
    bit   steady;
    int   samples_sent;
    int   settings_applied;
    int   errors;
    int   outstanding;
    int   compared;
    int   conflicts;

    dim_pin_if    pin_ch ();
    dim_result_if res_ch ();
    dim_cfg_if    cfg_ch ();

    digital_input_filter_mapper dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pins    (pin_ch),
        .results (res_ch),
        .cfg     (cfg_ch)
    );

    dim_tick_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .pin_mon     (pin_ch),
        .res_mon     (res_ch),
        .cfg_mon     (cfg_ch),
        .errors      (errors),
        .outstanding (outstanding),
        .compared    (compared),
        .conflicts   (conflicts)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result receiver: stall at random unless in a steady phase
    always @(negedge clk)
    begin
        res_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // End the run when no channel moves for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (pin_ch.valid && pin_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("digital_input_filter_mapper: mismatch");
        $finish;
    end

    // Offer one pin sample; entered and left at a falling edge
    task automatic send_pins(input logic [PIN_W-1:0] levels);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            pin_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pin_ch.valid      <= 1'b1;
        pin_ch.pin_levels <= levels;
        @(posedge clk);
        while (!pin_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        samples_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Hold off samples until every result has come back
    task automatic wait_idle();
        pin_ch.valid <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apply_config(input logic [FUNC_MAP_W-1:0] fm,
                                input logic [POL_MAP_W-1:0] pol,
                                input logic [FILT_HALF-1:0] lo,
                                input logic [FILT_HALF-1:0] hi,
                                input logic [FUNC_W-1:0] pas);
        wait_idle();
        write_reg(REG_SPARE, {$urandom, $urandom});
        write_reg(REG_FUNCTION_MAP, CFG_DATA_W'(fm));
        write_reg(REG_POLARITY_MAP, CFG_DATA_W'(pol));
        write_reg(REG_FILTER_LOW, CFG_DATA_W'(lo));
        write_reg(REG_FILTER_HIGH, CFG_DATA_W'(hi));
        write_reg(REG_PASSIVE, CFG_DATA_W'(pas));
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
        settings_applied++;
    endtask

    // Mostly distinct functions, with some unused, out-of-range and duplicates
    function automatic logic [FUNC_MAP_W-1:0] random_fmap();
        logic [FUNC_MAP_W-1:0] m;
        logic [FUNC_W-1:0]     f;
        int                    base;
        int                    stride;
        int                    c;
        int                    r;
        m      = '0;
        base   = $urandom_range(FUNCS - 1);
        stride = 2 * $urandom_range(15) + 1;
        for (c = 0; c < CHANNELS; c++)
        begin
            r = $urandom_range(99);
            if (r < 72)
                f = FUNC_W'((base + c * stride) % FUNCS + 1);
            else if (r < 80)
                f = '0;
            else if (r < 88)
                f = FUNC_W'($urandom_range(63, FUNCS + 1));
            else if (c > 0)
                f = m[$urandom_range(c - 1)*FUNC_W +: FUNC_W];
            else
                f = FUNC_W'(FUNCS);
            m[c*FUNC_W +: FUNC_W] = f;
        end
        return m;
    endfunction

    function automatic logic [POL_MAP_W-1:0] random_pol();
        logic [POL_MAP_W-1:0] m;
        int                   c;
        for (c = 0; c < CHANNELS; c++)
        begin
            m[c*POL_W +: POL_W] = ($urandom_range(99) < 65) ? POL_W'($urandom_range(1))
                                                            : POL_W'($urandom_range(7, 2));
        end
        return m;
    endfunction

    // Mostly short filter times so the debounce qualifies within a phase
    function automatic logic [FILT_HALF-1:0] random_filters();
        logic [FILT_HALF-1:0] m;
        int                   c;
        int                   r;
        for (c = 0; c < CHANNELS / 2; c++)
        begin
            r = $urandom_range(99);
            if (r < 55)
                m[c*CNT_W +: CNT_W] = CNT_W'($urandom_range(6));
            else if (r < 65)
                m[c*CNT_W +: CNT_W] = '0;
            else if (r < 73)
                m[c*CNT_W +: CNT_W] = '1;
            else if (r < 85)
                m[c*CNT_W +: CNT_W] = CNT_W'($urandom_range(40, 7));
            else
                m[c*CNT_W +: CNT_W] = CNT_W'($urandom);
        end
        return m;
    endfunction

    // Often make a mapped function passive so it still claims but drives nothing
    function automatic logic [FUNC_W-1:0] random_passive(input logic [FUNC_MAP_W-1:0] fm);
        logic [FUNC_W-1:0] f;
        int                r;
        r = $urandom_range(99);
        if (r < 40)
            f = '0;
        else if (r < 75)
        begin
            f = fm[$urandom_range(CHANNELS - 1)*FUNC_W +: FUNC_W];
            if (f > FUNCS)
                f = FUNC_W'(FUNCS);
        end
        else
            f = FUNC_W'($urandom_range(FUNCS, 1));
        return f;
    endfunction

    initial
    begin : stimulus
        logic [FUNC_MAP_W-1:0] fm;
        logic [POL_MAP_W-1:0]  pol;
        logic [FILT_HALF-1:0]  lo;
        logic [FILT_HALF-1:0]  hi;
        logic [PIN_W-1:0]      levels;
        int                    flip_pct [CHANNELS];
        int                    p;
        int                    i;
        int                    c;

        rst_n             = 1'b0;
        steady            = 1'b0;
        samples_sent      = 0;
        settings_applied  = 0;
        pin_ch.valid      = 1'b0;
        pin_ch.pin_levels = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_FUNCTION_MAP;
        cfg_ch.data       = '0;
        res_ch.ready      = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset registers: every channel unused
        send_pins('1);
        send_pins('0);

        // Polarity modes, filter extremes, out-of-range functions, passive channel
        apply_config({6'd0, 6'd4, 6'd63, 6'd33, 6'd3, 6'd2, 6'd1, 6'd32},
                     {POL_RSVD_7, POL_LOW, POL_RSVD_5, POL_EDGE,
                      POL_FALL, POL_RISE, POL_HIGH, POL_LOW},
                     {16'hFFFF, 16'd2, 16'd1, 16'd0},
                     {16'd0, 16'd3, 16'd0, 16'd0},
                     6'd4);
        send_pins(8'hFF);
        send_pins(8'hFF);
        send_pins(8'hFF);
        send_pins(8'h00);
        send_pins(8'h00);
        send_pins(8'h00);
        send_pins(8'hAA);
        send_pins(8'h55);
        send_pins(8'hFF);

        // Function change clears the old bit; duplicate claim on channel 2
        apply_config({6'd10, 6'd9, 6'd8, 6'd1, 6'd7, 6'd5, 6'd6, 6'd5},
                     {CHANNELS{POL_LOW}}, '0, '0, 6'd32);
        send_pins(8'hFF);
        send_pins(8'h00);
        send_pins(8'hFF);

        // Two channels claim the passive function
        apply_config({36'd0, 6'd32, 6'd32}, {CHANNELS{POL_HIGH}}, '0, '0, 6'd32);
        send_pins(8'h00);
        send_pins(8'hFF);

        // Unmap everything
        apply_config('0, '0, '0, '0, '0);
        send_pins(8'h5A);

        // Random phases
        levels = '0;
        for (p = 0; p < PHASES; p++)
        begin
            fm  = random_fmap();
            pol = random_pol();
            lo  = random_filters();
            hi  = random_filters();
            if (p == 0)
            begin
                lo = '0;
                hi = '0;
            end
            if (p == 1)
            begin
                lo = '1;
                hi = '1;
            end
            if (p == 2)
            begin
                fm  = '1;
                pol = '1;
            end
            apply_config(fm, pol, lo, hi, random_passive(fm));
            steady = (p == 6 || p == 7);
            for (c = 0; c < CHANNELS; c++)
            begin
                case ($urandom_range(4))
                    0:       flip_pct[c] = 2;
                    1:       flip_pct[c] = 5;
                    2:       flip_pct[c] = 10;
                    3:       flip_pct[c] = 30;
                    default: flip_pct[c] = 50;
                endcase
            end
            // Slowly varying pins so debounce settles, with some pure noise
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(99) < 15)
                begin
                    levels = PIN_W'($urandom_range(255));
                end
                else
                begin
                    for (c = 0; c < CHANNELS; c++)
                    begin
                        if ($urandom_range(99) < flip_pct[c])
                        begin
                            levels[c] = ~levels[c];
                        end
                    end
                end
                send_pins(levels);
            end
        end
        steady = 1'b0;

        wait_idle();
        $display("covered %0d pin samples under %0d register settings", samples_sent,
                 settings_applied);
        $display("%0d results compared, %0d of them with a duplicate claim", compared,
                 conflicts);
        if (errors == 0)
        begin
            $display("digital_input_filter_mapper: match");
        end
        else
        begin
            $display("digital_input_filter_mapper: mismatch");
        end
        $finish;
    end

endmodule

[digital_input_filter_mapper.f]
hdl/dim_pkg.sv
hdl/dim_if.sv
hdl/dim_claim.sv
hdl/dim_lane.sv
hdl/dim_merge.sv
hdl/digital_input_filter_mapper.sv
sim/dim_tick_checker.sv
sim/digital_input_filter_mapper_test.sv
